FILE: hw/rtl/kli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe interpolator package
// Shared constants, codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package kli_pkg;

   // Default configuration of the top level.
   localparam int KLI_MAX_KEYFRAMES = 128;
   localparam int KLI_CHANNELS      = 9;

   // Number of pose fields on the item and result beats.
   localparam int KLI_FIELDS = 9;

   // Register file.
   localparam int          KLI_CSR_ADDR_W       = 3;
   localparam logic [15:0] KLI_STEP_COUNT_RESET = 16'd190;

   // Signed Q16.16 saturation limits.
   localparam logic [31:0] KLI_Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] KLI_Q_MIN = 32'h8000_0000;

   // Item function codes; the fourth code is a no-op.
   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_START = 2'd1,
      FUNC_TICK  = 2'd2
   } kli_func_type;

   // Register indexes, decoded from the word address.
   typedef enum logic {
      CSR_STEP_COUNT  = 1'b0,
      CSR_FRAME_COUNT = 1'b1
   } kli_csr_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic mem_we;      // write the key row of the current beat
      logic mem_re;      // read one keyframe row
      logic load_pose;   // copy the read row into the channel values
      logic latch_a;     // hold the read row as the segment start
      logic div_start;   // start the increment division of one channel
      logic store_step;  // store the finished increment
      logic tick_add;    // add the increments to the channel values
      logic capture;     // load the result register
   } kli_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic rsp_free;
   } kli_sts_type;

endpackage

FILE: hw/rtl/kli_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe interpolator item channel
// Valid/ready channel that carries one load, start or tick item per beat.
// ----------------------------------------------------------------------------
interface kli_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [6:0]         frame_slot;
   logic signed [31:0] key_pos_x;
   logic signed [31:0] key_pos_y;
   logic signed [31:0] key_pos_z;
   logic signed [31:0] key_slew;
   logic signed [31:0] key_boom;
   logic signed [31:0] key_extension;
   logic signed [31:0] key_cable;
   logic signed [31:0] key_sway_x;
   logic signed [31:0] key_sway_z;

   modport source (
      output valid, func, frame_slot, key_pos_x, key_pos_y, key_pos_z, key_slew,
             key_boom, key_extension, key_cable, key_sway_x, key_sway_z,
      input  ready
   );

   modport sink (
      input  valid, func, frame_slot, key_pos_x, key_pos_y, key_pos_z, key_slew,
             key_boom, key_extension, key_cable, key_sway_x, key_sway_z,
      output ready
   );
endinterface

FILE: hw/rtl/kli_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe interpolator result channel
// Valid/ready channel that carries the pose after each item.
// ----------------------------------------------------------------------------
interface kli_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] slew;
   logic signed [31:0] boom;
   logic signed [31:0] extension;
   logic signed [31:0] cable;
   logic signed [31:0] sway_x;
   logic signed [31:0] sway_z;
   logic [6:0]         segment;
   logic               playing;

   modport source (
      output valid, pos_x, pos_y, pos_z, slew, boom, extension, cable, sway_x, sway_z,
             segment, playing,
      input  ready
   );

   modport sink (
      input  valid, pos_x, pos_y, pos_z, slew, boom, extension, cable, sway_x, sway_z,
             segment, playing,
      output ready
   );
endinterface

FILE: hw/rtl/kli_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe interpolator increment divider
// Bit-serial restoring divider: signed 33-bit difference over an unsigned
// 16-bit step count, truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module kli_div import kli_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] dividend,
   input  logic [15:0]        divisor,
   output logic               done,
   output logic [31:0]        quotient
);

   localparam int DIV_BITS = 32;
   localparam int CNT_W    = $clog2(DIV_BITS);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             neg_ff;
   logic [15:0]      dvs_ff;
   logic [15:0]      rem_ff;
   logic [31:0]      quo_ff;

   logic [32:0] neg_dividend;
   logic [31:0] mag;
   logic [16:0] rem_shift;
   logic [16:0] rem_diff;
   logic        take;
   logic [15:0] rem_in;
   logic [31:0] quo_in;

   // Magnitude of the dividend; it always fits 32 bits.
   assign neg_dividend = -dividend;
   assign mag          = dividend[32] ? neg_dividend[31:0] : dividend[31:0];

   // One quotient bit per cycle.
   assign rem_shift = {rem_ff, quo_ff[DIV_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};
   assign take      = (rem_shift >= {1'b0, dvs_ff});
   assign rem_in    = take ? rem_diff[15:0] : rem_shift[15:0];
   assign quo_in    = {quo_ff[DIV_BITS-2:0], take};

   // Control and iteration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operand and partial result registers.
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[32];
         dvs_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= mag;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // Sign restore with saturation; a zero step count gives a zero increment.
   always_comb begin
      if (dvs_ff == '0) begin
         quotient = '0;
      end else if (!neg_ff) begin
         quotient = quo_ff[31] ? KLI_Q_MAX : quo_ff;
      end else begin
         quotient = (quo_ff > KLI_Q_MIN) ? KLI_Q_MIN : -quo_ff;
      end
   end

   assign done = done_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

endmodule

FILE: hw/rtl/kli_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe interpolator datapath
// Keyframe memory, channel values and increments, the shared divider and the
// result register.
// ----------------------------------------------------------------------------
module kli_dpath import kli_pkg::*; #(
   parameter  int MAX_KEYFRAMES = KLI_MAX_KEYFRAMES,
   parameter  int CHANNELS      = KLI_CHANNELS,
   localparam int ADDR_W        = $clog2(MAX_KEYFRAMES),
   localparam int CH_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  kli_cmd_type                      cmd,
   input  logic [ADDR_W-1:0]                rd_addr,
   input  logic [CH_W-1:0]                  chan,
   input  logic [6:0]                       seg,
   input  logic                             playing,
   input  logic [15:0]                      step_count,
   input  logic [6:0]                       frame_slot,
   input  logic [KLI_FIELDS-1:0][31:0]      key_row,
   input  logic                             rsp_ready,
   output kli_sts_type                      sts,
   output logic                             rsp_valid,
   output logic [KLI_FIELDS-1:0][31:0]      rsp_values,
   output logic [6:0]                       rsp_segment,
   output logic                             rsp_playing
);

   // Saturating signed add of two Q16.16 values.
   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {a[31], a} + {b[31], b};
      if (sum[32] != sum[31]) begin
         return sum[32] ? KLI_Q_MIN : KLI_Q_MAX;
      end
      return sum[31:0];
   endfunction

   logic [CHANNELS-1:0][31:0] key_mem [MAX_KEYFRAMES];
   logic [CHANNELS-1:0][31:0] rd_ff;
   logic [CHANNELS-1:0][31:0] a_row_ff;
   logic [CHANNELS-1:0][31:0] values_ff;
   logic [CHANNELS-1:0][31:0] steps_ff;

   logic                        rsp_valid_ff;
   logic [KLI_FIELDS-1:0][31:0] rsp_values_ff;
   logic [6:0]                  rsp_segment_ff;
   logic                        rsp_playing_ff;

   logic [CHANNELS-1:0][31:0]   wr_row;
   logic [KLI_FIELDS-1:0][31:0] values_full;
   logic [31:0]                 slot_wide;
   logic [ADDR_W-1:0]           wr_addr;
   logic [31:0]                 a_sel;
   logic [31:0]                 b_sel;
   logic signed [32:0]          diff;
   logic                        div_done;
   logic [31:0]                 div_quotient;

   // Row layout of the memory and of the result; unused channels read zero.
   always_comb begin
      wr_row      = '0;
      values_full = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         wr_row[c]      = key_row[c];
         values_full[c] = values_ff[c];
      end
   end

   assign slot_wide = 32'(frame_slot);
   assign wr_addr   = slot_wide[ADDR_W-1:0];

   // Keyframe memory: one row per keyframe, registered read.
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         key_mem[wr_addr] <= wr_row;
      end
      if (cmd.mem_re) begin
         rd_ff <= key_mem[rd_addr];
      end
   end

   // Segment start row.
   always_ff @(posedge clock) begin
      if (cmd.latch_a) begin
         a_row_ff <= rd_ff;
      end
   end

   // Difference of the selected channel over the segment.
   assign a_sel = a_row_ff[chan];
   assign b_sel = rd_ff[chan];
   assign diff  = $signed({b_sel[31], b_sel}) - $signed({a_sel[31], a_sel});

   kli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (diff),
      .divisor  (step_count),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Channel values and increments.
   always_ff @(posedge clock) begin
      if (reset) begin
         values_ff <= '0;
         steps_ff  <= '0;
      end else begin
         if (cmd.load_pose) begin
            values_ff <= rd_ff;
         end else if (cmd.tick_add) begin
            for (int c = 0; c < CHANNELS; c++) begin
               values_ff[c] <= sat_add(values_ff[c], steps_ff[c]);
            end
         end
         if (cmd.store_step) begin
            steps_ff[chan] <= div_quotient;
         end
      end
   end

   // Result register; it frees up in the cycle its beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.capture) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rsp_values_ff  <= values_full;
         rsp_segment_ff <= seg;
         rsp_playing_ff <= playing;
      end
   end

   assign sts.div_done = div_done;
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_values  = rsp_values_ff;
   assign rsp_segment = rsp_segment_ff;
   assign rsp_playing = rsp_playing_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before its beat was taken");

endmodule

FILE: hw/rtl/kli_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe interpolator controller
// Decodes items, keeps the playback state and sequences the datapath through
// pose reloads and the per-channel increment divisions.
// ----------------------------------------------------------------------------
module kli_ctrl import kli_pkg::*; #(
   parameter  int MAX_KEYFRAMES = KLI_MAX_KEYFRAMES,
   parameter  int CHANNELS      = KLI_CHANNELS,
   localparam int SEG_W         = $clog2(MAX_KEYFRAMES),
   localparam int CH_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
   localparam int CNT_W         = $clog2(MAX_KEYFRAMES + 256) + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_func,
   input  logic [6:0]        req_frame_slot,
   input  logic [15:0]       step_count,
   input  logic [7:0]        frame_count,
   input  kli_sts_type       sts,
   output kli_cmd_type       cmd,
   output logic [SEG_W-1:0]  rd_addr,
   output logic [CH_W-1:0]   chan,
   output logic [6:0]        seg,
   output logic              playing
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD0,
      ST_POSE,
      ST_RDA,
      ST_CAPA,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_RESULT
   } state_type;

   state_type        state_ff, state_in;
   logic [15:0]      tick_ff, tick_in;
   logic [SEG_W-1:0] seg_ff, seg_in;
   logic             active_ff, active_in;
   logic [CH_W-1:0]  ch_ff, ch_in;

   logic [CNT_W-1:0] max_ext;
   logic [CNT_W-1:0] count_ext;
   logic [CNT_W-1:0] eff_count;
   logic [CNT_W-1:0] seg_ext;
   logic             start_ok;
   logic             slot_ok;
   logic             tick_done;
   logic             wrap;
   logic [31:0]      seg_wide;

   // Effective frame count and segment limit checks.
   assign max_ext   = CNT_W'(MAX_KEYFRAMES);
   assign count_ext = CNT_W'(frame_count);
   assign eff_count = (count_ext > max_ext) ? max_ext : count_ext;
   assign seg_ext   = CNT_W'(seg_ff);
   assign start_ok  = (eff_count >= CNT_W'(2));
   assign slot_ok   = (CNT_W'(req_frame_slot) < max_ext);
   assign tick_done = (tick_ff >= step_count);
   assign wrap      = ((seg_ext + CNT_W'(3)) > eff_count);

   assign req_ready = (state_ff == ST_IDLE);

   // Next state, playback state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      tick_in   = tick_ff;
      seg_in    = seg_ff;
      active_in = active_ff;
      ch_in     = ch_ff;
      cmd       = '0;
      rd_addr   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RESULT;
               unique case (kli_func_type'(req_func))
                  FUNC_LOAD: begin
                     cmd.mem_we = slot_ok;
                  end
                  FUNC_START: begin
                     if (start_ok) begin
                        seg_in    = '0;
                        tick_in   = '0;
                        active_in = 1'b1;
                        state_in  = ST_RD0;
                     end
                  end
                  FUNC_TICK: begin
                     if (active_ff) begin
                        if (tick_done) begin
                           tick_in = '0;
                           if (wrap) begin
                              seg_in   = '0;
                              state_in = ST_RD0;
                           end else begin
                              seg_in   = seg_ff + SEG_W'(1);
                              state_in = ST_RDA;
                           end
                        end else begin
                           cmd.tick_add = 1'b1;
                           tick_in      = tick_ff + 16'd1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RD0: begin
            cmd.mem_re = 1'b1;
            rd_addr    = '0;
            state_in   = ST_POSE;
         end
         ST_POSE: begin
            cmd.load_pose = 1'b1;
            state_in      = ST_RDA;
         end
         ST_RDA: begin
            cmd.mem_re = 1'b1;
            rd_addr    = seg_ff;
            state_in   = ST_CAPA;
         end
         ST_CAPA: begin
            cmd.latch_a = 1'b1;
            cmd.mem_re  = 1'b1;
            rd_addr     = seg_ff + SEG_W'(1);
            ch_in       = '0;
            state_in    = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (sts.div_done) begin
               cmd.store_step = 1'b1;
               if (ch_ff == CH_W'(CHANNELS - 1)) begin
                  state_in = ST_RESULT;
               end else begin
                  ch_in    = ch_ff + CH_W'(1);
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_RESULT: begin
            if (sts.rsp_free) begin
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and playback registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tick_ff   <= '0;
         seg_ff    <= '0;
         active_ff <= 1'b0;
         ch_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         tick_ff   <= tick_in;
         seg_ff    <= seg_in;
         active_ff <= active_in;
         ch_ff     <= ch_in;
      end
   end

   assign seg_wide = 32'(seg_ff);
   assign seg      = seg_wide[6:0];
   assign playing  = active_ff;
   assign chan     = ch_ff;

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      seg_wide <= 32'(MAX_KEYFRAMES - 2))
      else $error("segment index beyond the last segment");

   a_start_reload: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_func == FUNC_START) && start_ok)
      |=> (active_ff && (seg_ff == '0) && (tick_ff == '0) && (state_ff == ST_RD0)))
      else $error("accepted start did not begin a pose reload");

   a_plain_tick: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_func == FUNC_TICK) && active_ff && !tick_done)
      |=> (state_ff == ST_RESULT))
      else $error("interpolation tick did not go straight to its result");

endmodule

FILE: hw/rtl/keyframe_linear_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe linear interpolator
// Keyframe table, nine-channel Q16.16 pose player and register file.
// ----------------------------------------------------------------------------
// Every accepted item returns one result beat with the pose after that item.
// Load items, ticks that interpolate, idle ticks, unknown codes and starts that
// are refused go from acceptance straight to the result state, which loads
// the result register once it is free. A start, and a tick that closes a
// segment, recompute the increments on one shared bit-serial divider, one
// channel after another, once the two keyframes of the segment are read
// and, on a start or a wrap, after frame 0 is first reloaded into the pose.
// A receiver that holds off a waiting result can delay the result of the
// next item. One item is in work at a time: a new item is accepted only
// once the result of the last one is loaded, and the result register lets
// the next item be accepted while the previous result is still waiting.
// The keyframe memory has no clearing pass, so starts and ticks may follow
// reset at once; reading a keyframe slot that was never loaded gives
// undefined pose data.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_top import kli_pkg::*; #(
   parameter int MAX_KEYFRAMES = KLI_MAX_KEYFRAMES,
   parameter int CHANNELS      = KLI_CHANNELS
) (
   input  logic                      clock,
   input  logic                      reset,
   kli_req_if.sink                   req_chan,
   kli_rsp_if.source                 rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [KLI_CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int SEG_W = $clog2(MAX_KEYFRAMES);
   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [15:0] step_count_ff;
   logic [7:0]  frame_count_ff;
   kli_csr_type csr_index;
   logic        csr_write;

   kli_cmd_type                 cmd;
   kli_sts_type                 sts;
   logic [SEG_W-1:0]            rd_addr;
   logic [CH_W-1:0]             chan;
   logic [6:0]                  seg;
   logic                        playing;
   logic [KLI_FIELDS-1:0][31:0] key_row;
   logic [KLI_FIELDS-1:0][31:0] rsp_values;

   // Register file: word index from the address, writes on the access phase.
   assign csr_pready = 1'b1;
   assign csr_index  = kli_csr_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff  <= KLI_STEP_COUNT_RESET;
         frame_count_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_STEP_COUNT:  step_count_ff  <= csr_pwdata[15:0];
            CSR_FRAME_COUNT: frame_count_ff <= csr_pwdata[7:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_STEP_COUNT:  csr_prdata = 32'(step_count_ff);
         CSR_FRAME_COUNT: csr_prdata = 32'(frame_count_ff);
      endcase
   end

   // Keyframe fields in channel order.
   assign key_row[0] = req_chan.key_pos_x;
   assign key_row[1] = req_chan.key_pos_y;
   assign key_row[2] = req_chan.key_pos_z;
   assign key_row[3] = req_chan.key_slew;
   assign key_row[4] = req_chan.key_boom;
   assign key_row[5] = req_chan.key_extension;
   assign key_row[6] = req_chan.key_cable;
   assign key_row[7] = req_chan.key_sway_x;
   assign key_row[8] = req_chan.key_sway_z;

   kli_ctrl #(
      .MAX_KEYFRAMES (MAX_KEYFRAMES),
      .CHANNELS      (CHANNELS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_func       (req_chan.func),
      .req_frame_slot (req_chan.frame_slot),
      .step_count     (step_count_ff),
      .frame_count    (frame_count_ff),
      .sts            (sts),
      .cmd            (cmd),
      .rd_addr        (rd_addr),
      .chan           (chan),
      .seg            (seg),
      .playing        (playing)
   );

   kli_dpath #(
      .MAX_KEYFRAMES (MAX_KEYFRAMES),
      .CHANNELS      (CHANNELS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .chan        (chan),
      .seg         (seg),
      .playing     (playing),
      .step_count  (step_count_ff),
      .frame_slot  (req_chan.frame_slot),
      .key_row     (key_row),
      .rsp_ready   (rsp_chan.ready),
      .sts         (sts),
      .rsp_valid   (rsp_chan.valid),
      .rsp_values  (rsp_values),
      .rsp_segment (rsp_chan.segment),
      .rsp_playing (rsp_chan.playing)
   );

   // Result fields in channel order.
   assign rsp_chan.pos_x     = rsp_values[0];
   assign rsp_chan.pos_y     = rsp_values[1];
   assign rsp_chan.pos_z     = rsp_values[2];
   assign rsp_chan.slew      = rsp_values[3];
   assign rsp_chan.boom      = rsp_values[4];
   assign rsp_chan.extension = rsp_values[5];
   assign rsp_chan.cable     = rsp_values[6];
   assign rsp_chan.sway_x    = rsp_values[7];
   assign rsp_chan.sway_z    = rsp_values[8];

endmodule

FILE: sim/kli_pose_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe interpolator pose checker
// Watches the register port and both channels, keeps its own model of the
// keyframe player, predicts the pose after every accepted item beat and
// compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module kli_pose_checker import kli_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   kli_req_if                        req_mon,
   kli_rsp_if                        rsp_mon,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [KLI_CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   input  logic                      csr_pready,
   output int                        mismatches,
   output int                        outstanding
);

   localparam longint Q_HIGH      = 64'sd2147483647;
   localparam longint Q_LOW       = -64'sd2147483648;
   localparam int     REPORT_MAX  = 10;

   // One result beat as the block presents it.
   typedef struct packed {
      logic [KLI_FIELDS-1:0][31:0] chan;
      logic [6:0]                  segment;
      logic                        playing;
   } pose_beat_type;

   // Poses predicted for accepted items, oldest first.
   pose_beat_type pose_q[$];

   // Model of the player and of its registers.
   logic [31:0] key_store [KLI_MAX_KEYFRAMES][KLI_FIELDS];
   logic [31:0] chan_value [KLI_FIELDS];
   logic [31:0] chan_incr [KLI_FIELDS];
   int          tick_count;
   int          seg_idx;
   logic        playing;
   logic [15:0] step_count_q;
   logic [7:0]  frame_count_q;
   int          errors;

   logic [KLI_FIELDS-1:0][31:0] item_keys;
   pose_beat_type               seen_beat;

   string chan_names [KLI_FIELDS] = '{"pos_x", "pos_y", "pos_z", "slew", "boom",
                                      "extension", "cable", "sway_x", "sway_z"};

   // Gather the key fields of the item beat and the fields of the result beat.
   always_comb begin
      item_keys[0] = req_mon.key_pos_x;
      item_keys[1] = req_mon.key_pos_y;
      item_keys[2] = req_mon.key_pos_z;
      item_keys[3] = req_mon.key_slew;
      item_keys[4] = req_mon.key_boom;
      item_keys[5] = req_mon.key_extension;
      item_keys[6] = req_mon.key_cable;
      item_keys[7] = req_mon.key_sway_x;
      item_keys[8] = req_mon.key_sway_z;
   end

   always_comb begin
      seen_beat.chan[0] = rsp_mon.pos_x;
      seen_beat.chan[1] = rsp_mon.pos_y;
      seen_beat.chan[2] = rsp_mon.pos_z;
      seen_beat.chan[3] = rsp_mon.slew;
      seen_beat.chan[4] = rsp_mon.boom;
      seen_beat.chan[5] = rsp_mon.extension;
      seen_beat.chan[6] = rsp_mon.cable;
      seen_beat.chan[7] = rsp_mon.sway_x;
      seen_beat.chan[8] = rsp_mon.sway_z;
      seen_beat.segment = rsp_mon.segment;
      seen_beat.playing = rsp_mon.playing;
   end

   // Clamp a wide value to the signed Q16.16 range.
   function automatic logic [31:0] clamp_q(input longint v);
      if (v > Q_HIGH) return KLI_Q_MAX;
      if (v < Q_LOW) return KLI_Q_MIN;
      return v[31:0];
   endfunction

   // Frame count as the player uses it; an oversized count means a full table.
   function automatic int usable_frames();
      return (int'(frame_count_q) > KLI_MAX_KEYFRAMES) ? KLI_MAX_KEYFRAMES
                                                       : int'(frame_count_q);
   endfunction

   task automatic reload_first_pose();
      for (int c = 0; c < KLI_CHANNELS; c++) chan_value[c] = key_store[0][c];
   endtask

   // Per-channel increment of the current segment, truncated toward zero.
   task automatic derive_increments();
      int     first;
      longint span;
      first = seg_idx;
      if (first + 1 >= KLI_MAX_KEYFRAMES) first = 0;
      for (int c = 0; c < KLI_CHANNELS; c++) begin
         span = longint'(signed'(key_store[first + 1][c]))
              - longint'(signed'(key_store[first][c]));
         chan_incr[c] = (step_count_q == 16'd0) ? 32'd0
                                                : clamp_q(span / longint'(step_count_q));
      end
   endtask

   // Advance the model by the item beat on the input channel.
   task automatic play_item();
      case (req_mon.func)
         FUNC_LOAD: begin
            if (int'(req_mon.frame_slot) < KLI_MAX_KEYFRAMES)
               for (int c = 0; c < KLI_CHANNELS; c++)
                  key_store[req_mon.frame_slot][c] = item_keys[c];
         end
         FUNC_START: begin
            // A start with fewer than two frames leaves everything as it is.
            if (usable_frames() >= 2) begin
               seg_idx    = 0;
               tick_count = 0;
               reload_first_pose();
               derive_increments();
               playing = 1'b1;
            end
         end
         FUNC_TICK: begin
            if (playing) begin
               if (tick_count >= int'(step_count_q)) begin
                  // Segment done: move on, wrapping to frame 0 past the last one.
                  seg_idx++;
                  tick_count = 0;
                  if (seg_idx + 2 > usable_frames()) begin
                     seg_idx = 0;
                     reload_first_pose();
                  end
                  derive_increments();
               end else begin
                  for (int c = 0; c < KLI_CHANNELS; c++)
                     chan_value[c] = clamp_q(longint'(signed'(chan_value[c]))
                                           + longint'(signed'(chan_incr[c])));
                  tick_count++;
               end
            end
         end
         default: ;
      endcase
   endtask

   function automatic pose_beat_type current_pose();
      pose_beat_type beat;
      for (int c = 0; c < KLI_FIELDS; c++)
         beat.chan[c] = (c < KLI_CHANNELS) ? chan_value[c] : 32'd0;
      beat.segment = seg_idx[6:0];
      beat.playing = playing;
      return beat;
   endfunction

   task automatic note_mismatch(input string field, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      errors++;
      if (errors <= REPORT_MAX)
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
   endtask

   // Track register writes and beats on both channels.
   always @(posedge clock) begin
      pose_beat_type want;
      if (reset) begin
         pose_q.delete();
         for (int c = 0; c < KLI_FIELDS; c++) begin
            chan_value[c] = 32'd0;
            chan_incr[c]  = 32'd0;
         end
         tick_count    = 0;
         seg_idx       = 0;
         playing       = 1'b0;
         step_count_q  = KLI_STEP_COUNT_RESET;
         frame_count_q = 8'd0;
         errors        = 0;
         mismatches  <= 0;
         outstanding <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (kli_csr_type'(csr_paddr[KLI_CSR_ADDR_W-1:2]))
               CSR_STEP_COUNT:  step_count_q  = csr_pwdata[15:0];
               CSR_FRAME_COUNT: frame_count_q = csr_pwdata[7:0];
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            play_item();
            pose_q.push_back(current_pose());
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pose_q.size() == 0) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("%0t: result beat with no pending prediction", $time);
            end else begin
               want = pose_q.pop_front();
               for (int c = 0; c < KLI_FIELDS; c++)
                  if (seen_beat.chan[c] !== want.chan[c])
                     note_mismatch(chan_names[c], want.chan[c], seen_beat.chan[c]);
               if (seen_beat.segment !== want.segment)
                  note_mismatch("segment", 32'(want.segment), 32'(seen_beat.segment));
               if (seen_beat.playing !== want.playing)
                  note_mismatch("playing", 32'(want.playing), 32'(seen_beat.playing));
            end
         end

         mismatches  <= errors;
         outstanding <= pose_q.size();
      end
   end

endmodule

FILE: sim/keyframe_linear_interpolator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe linear interpolator testbench
// Drives load, start, tick and no-op beats in random bursts against a
// stalling receiver, reprograms step and frame counts between phases, and
// lets the pose checker predict and compare every result beat.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_top_tb;
   import kli_pkg::*;

   localparam int          CLOCK_HALF       = 10;
   localparam int          RESET_CYCLES     = 8;
   localparam int unsigned CYCLE_LIMIT      = 1_500_000;
   localparam int          ITEM_TARGET      = 600;
   localparam int          SETTLE_CYCLES    = 330;
   localparam int          LONG_HOLD_CYCLES = 800;
   localparam int          LONG_HOLD_PHASE  = 2;
   localparam logic [1:0]  FUNC_NOP         = 2'd3;

   // One item beat.
   typedef struct packed {
      logic [1:0]                  func;
      logic [6:0]                  slot;
      logic [KLI_FIELDS-1:0][31:0] key;
   } pose_item_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [KLI_CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]               csr_pwdata;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;
   int                        mismatches;
   int                        outstanding;

   int unsigned cycle_count = 0;
   bit          long_hold_req = 1'b0;
   bit          slot_loaded [KLI_MAX_KEYFRAMES];
   bit          tb_playing = 1'b0;
   bit          overfull_done = 1'b0;
   int          tb_frames = 0;
   int          items_counted = 0;
   int          burst_left = 0;

   kli_req_if req_chan ();
   kli_rsp_if rsp_chan ();

   keyframe_linear_interpolator_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   kli_pose_checker pose_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #CLOCK_HALF clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: random stall modes, plus one long hold-off on request.
   initial begin
      int mode;
      int mode_left;
      int hold_left;
      bit hold_taken;
      mode       = 0;
      mode_left  = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (long_hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 300);
            end else begin
               mode_left--;
            end
            case (mode)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= ((mode_left % 5) < 2);
            endcase
         end
      end
   end

   // Key value biased toward the Q16.16 extremes and small magnitudes.
   function automatic logic [31:0] rand_key();
      case ($urandom_range(0, 7))
         0:       return KLI_Q_MAX;
         1:       return KLI_Q_MIN;
         2:       return 32'($urandom_range(0, 2047)) - 32'd1024;
         default: return $urandom();
      endcase
   endfunction

   function automatic pose_item_type make_item(input logic [1:0] func, input int slot);
      pose_item_type it;
      it.func = func;
      it.slot = slot[6:0];
      for (int c = 0; c < KLI_FIELDS; c++) it.key[c] = rand_key();
      return it;
   endfunction

   // Length of the run of keyframe slots loaded from slot 0 upward.
   function automatic int loaded_prefix();
      for (int s = 0; s < KLI_MAX_KEYFRAMES; s++)
         if (!slot_loaded[s]) return s;
      return KLI_MAX_KEYFRAMES;
   endfunction

   function automatic int pick_steps();
      case ($urandom_range(0, 19))
         0:          return 0;
         1:          return 65535;
         2:          return $urandom_range(1, 65535);
         3, 4, 5:    return $urandom_range(9, 40);
         default:    return $urandom_range(1, 8);
      endcase
   endfunction

   // A frame count that never makes the player read an unloaded slot.
   function automatic int pick_frames(input int prefix);
      int r;
      r = $urandom_range(0, 7);
      if (prefix < 2) return $urandom_range(0, 1);
      if (prefix == KLI_MAX_KEYFRAMES) begin
         if (!overfull_done) begin
            overfull_done = 1'b1;
            return 255;
         end
         if (r == 0) return KLI_MAX_KEYFRAMES;
         if (r == 1) return $urandom_range(KLI_MAX_KEYFRAMES + 1, 255);
      end
      if (r == 2) return $urandom_range(0, 1);
      if (r <= 5) return $urandom_range(2, (prefix < 4) ? prefix : 4);
      return $urandom_range(2, prefix);
   endfunction

   // Offer one item beat, wait for it to be taken, then maybe leave a gap.
   task automatic send_item(input pose_item_type it);
      int usable;
      int gap;
      req_chan.valid         <= 1'b1;
      req_chan.func          <= it.func;
      req_chan.frame_slot    <= it.slot;
      req_chan.key_pos_x     <= it.key[0];
      req_chan.key_pos_y     <= it.key[1];
      req_chan.key_pos_z     <= it.key[2];
      req_chan.key_slew      <= it.key[3];
      req_chan.key_boom      <= it.key[4];
      req_chan.key_extension <= it.key[5];
      req_chan.key_cable     <= it.key[6];
      req_chan.key_sway_x    <= it.key[7];
      req_chan.key_sway_z    <= it.key[8];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);

      // Only beats that change or advance the player count toward the target.
      usable = (tb_frames > KLI_MAX_KEYFRAMES) ? KLI_MAX_KEYFRAMES : tb_frames;
      if (it.func == FUNC_LOAD) begin
         slot_loaded[it.slot] = 1'b1;
         items_counted++;
      end else if (it.func == FUNC_START && usable >= 2) begin
         tb_playing = 1'b1;
         items_counted++;
      end else if (it.func == FUNC_TICK && tb_playing) begin
         items_counted++;
      end

      // Bursts of back-to-back beats separated by random gaps.
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 12);
         case ($urandom_range(0, 7))
            0, 1:    gap = 0;
            2:       gap = $urandom_range(20, 320);
            default: gap = $urandom_range(1, 8);
         endcase
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop offering and wait until every predicted result beat has arrived.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Register write: setup cycle, access cycle, then the bus goes idle.
   task automatic csr_write(input kli_csr_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == CSR_FRAME_COUNT) tb_frames = value[7:0];
      @(posedge clock);
   endtask

   // One random phase: grow the table, new settings, then playback with noise.
   task automatic run_random_phase(input int phase_no);
      int prefix;
      int n;
      int r;
      prefix = loaded_prefix();
      if (prefix < KLI_MAX_KEYFRAMES && $urandom_range(0, 2) != 0) begin
         n = $urandom_range(2, 24);
         if (prefix + n > KLI_MAX_KEYFRAMES) n = KLI_MAX_KEYFRAMES - prefix;
         for (int k = 0; k < n; k++) send_item(make_item(FUNC_LOAD, prefix + k));
         wait_idle();
      end

      // Registers change only while the block is idle.
      prefix = loaded_prefix();
      r = $urandom_range(0, 3);
      if (r != 1)
         csr_write(CSR_STEP_COUNT, {16'($urandom()), 16'(pick_steps())});
      if (r != 0)
         csr_write(CSR_FRAME_COUNT, {24'($urandom()), 8'(pick_frames(prefix))});

      if (phase_no == LONG_HOLD_PHASE) long_hold_req <= 1'b1;

      if ($urandom_range(0, 3) != 0)
         send_item(make_item(FUNC_START, $urandom_range(0, 127)));
      n = $urandom_range(4, 40);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 19))
            0:       send_item(make_item(FUNC_NOP, $urandom_range(0, 127)));
            1:       send_item(make_item(FUNC_LOAD, $urandom_range(0, 127)));
            2:       send_item(make_item(FUNC_START, $urandom_range(0, 127)));
            default: send_item(make_item(FUNC_TICK, $urandom_range(0, 127)));
         endcase
      end
      wait_idle();
   endtask

   // Main stimulus and verdict.
   initial begin
      pose_item_type it;
      int            phase_no;

      reset                  = 1'b1;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;
      req_chan.valid         = 1'b0;
      req_chan.func          = FUNC_LOAD;
      req_chan.frame_slot    = '0;
      req_chan.key_pos_x     = '0;
      req_chan.key_pos_y     = '0;
      req_chan.key_pos_z     = '0;
      req_chan.key_slew      = '0;
      req_chan.key_boom      = '0;
      req_chan.key_extension = '0;
      req_chan.key_cable     = '0;
      req_chan.key_sway_x    = '0;
      req_chan.key_sway_z    = '0;
      for (int s = 0; s < KLI_MAX_KEYFRAMES; s++) slot_loaded[s] = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: idle tick, unknown code and a start with no frames.
      send_item(make_item(FUNC_TICK, 0));
      send_item(make_item(FUNC_NOP, 127));
      send_item(make_item(FUNC_START, 0));
      // Frames 0 and 1 sit at opposite extremes, so increments saturate at a step count of one.
      it = make_item(FUNC_LOAD, 0);
      for (int c = 0; c < KLI_FIELDS; c++) it.key[c] = (c % 2 == 0) ? KLI_Q_MAX : KLI_Q_MIN;
      send_item(it);
      it = make_item(FUNC_LOAD, 1);
      for (int c = 0; c < KLI_FIELDS; c++) it.key[c] = (c % 2 == 0) ? KLI_Q_MIN : KLI_Q_MAX;
      send_item(it);
      it = make_item(FUNC_LOAD, 127);
      for (int c = 0; c < KLI_FIELDS; c++) it.key[c] = 32'hFFFF_FFFF;
      send_item(it);
      send_item(make_item(FUNC_LOAD, 2));
      send_item(make_item(FUNC_START, 0));
      wait_idle();

      // One step per segment: a start refused on one frame, then a full loop.
      csr_write(CSR_STEP_COUNT, 32'd1);
      csr_write(CSR_FRAME_COUNT, 32'd1);
      send_item(make_item(FUNC_START, 0));
      wait_idle();
      csr_write(CSR_FRAME_COUNT, 32'd2);
      send_item(make_item(FUNC_START, 0));
      repeat (3) send_item(make_item(FUNC_TICK, 0));
      wait_idle();

      // Longest segment with the saturated increments: the sums overflow.
      csr_write(CSR_STEP_COUNT, 32'd65535);
      repeat (4) send_item(make_item(FUNC_TICK, 0));
      wait_idle();

      // Zero steps: every tick moves to the next segment.
      csr_write(CSR_STEP_COUNT, 32'd0);
      csr_write(CSR_FRAME_COUNT, 32'd3);
      send_item(make_item(FUNC_START, 0));
      repeat (3) send_item(make_item(FUNC_TICK, 0));
      wait_idle();

      // Frame count shrunk while playing in the second segment.
      csr_write(CSR_FRAME_COUNT, 32'd2);
      repeat (2) send_item(make_item(FUNC_TICK, 0));
      wait_idle();

      phase_no = 0;
      while (items_counted < ITEM_TARGET) begin
         run_random_phase(phase_no);
         phase_no++;
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/kli_pkg.sv
hw/rtl/kli_req_if.sv
hw/rtl/kli_rsp_if.sv
hw/rtl/kli_div.sv
hw/rtl/kli_dpath.sv
hw/rtl/kli_ctrl.sv
hw/rtl/keyframe_linear_interpolator_top.sv
sim/kli_pose_checker.sv
sim/keyframe_linear_interpolator_top_tb.sv
